// File: design/spca_pkg.sv
// ----------------------------------------------------------------------------
// spca_pkg
// shared types, constants and register indexes for the sgm path cost
// aggregation block
// ----------------------------------------------------------------------------
`default_nettype none

package spca_pkg;

    localparam int DISPARITY_DEPTH_DEF = 128;

    localparam int COST_W  = 13;
    localparam int PIXEL_W = 12;
    localparam int DISP_W  = 7;
    localparam int SUM_W   = 18;
    localparam int PS_W    = 8;
    localparam int PL_W    = 10;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [COST_W-1:0] COST_MAX = '1;
    localparam logic [SUM_W-1:0]  SUM_MAX  = '1;

    localparam logic [PS_W-1:0]   PENALTY_SMALL_RST = 8'd8;
    localparam logic [PL_W-1:0]   PENALTY_LARGE_RST = 10'd64;
    localparam logic [DISP_W-1:0] MAX_DISP_RST      = 7'd63;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PENALTY_SMALL = 2'd0,
        CFG_PENALTY_LARGE = 2'd1,
        CFG_MAX_DISPARITY = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic [PS_W-1:0]   penalty_small;
        logic [PL_W-1:0]   penalty_large;
        logic [DISP_W-1:0] max_disparity;
    } t_cfg;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel_cost;
        logic [DISP_W-1:0]  disparity;
        logic               path_start;
        logic [SUM_W-1:0]   partial_sum;
    } t_in_item;

    typedef struct packed {
        logic [COST_W-1:0] path_cost;
        logic [SUM_W-1:0]  new_sum;
        logic              pixel_done;
    } t_out_item;

    // path state seen by the cost unit for one transaction
    typedef struct packed {
        logic [COST_W-1:0] old_here;
        logic [COST_W-1:0] old_up;
        logic [COST_W-1:0] held_lower;
        logic [COST_W-1:0] prev_min;
    } t_path_state;

endpackage

`default_nettype wire

// File: design/spca_cfg_regs.sv
// ----------------------------------------------------------------------------
// spca_cfg_regs
// configuration register file, always ready, unknown indexes are dropped
// ----------------------------------------------------------------------------
`default_nettype none

module spca_cfg_regs (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire [spca_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire [spca_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output spca_pkg::t_cfg                   o_cfg
);
    import spca_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PENALTY_SMALL: n_cfg.penalty_small = i_cfg_data[PS_W-1:0];
                CFG_PENALTY_LARGE: n_cfg.penalty_large = i_cfg_data[PL_W-1:0];
                CFG_MAX_DISPARITY: n_cfg.max_disparity = i_cfg_data[DISP_W-1:0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.penalty_small <= PENALTY_SMALL_RST;
            r_cfg.penalty_large <= PENALTY_LARGE_RST;
            r_cfg.max_disparity <= MAX_DISP_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

`default_nettype wire

// File: design/spca_cost_ram.sv
// ----------------------------------------------------------------------------
// spca_cost_ram
// previous path cost store, two registered read ports and one write port
// ----------------------------------------------------------------------------
`default_nettype none

module spca_cost_ram #(
    parameter int DEPTH = spca_pkg::DISPARITY_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire                          i_clk,
    input  wire                          i_rd_en,
    input  wire [AW-1:0]                 i_rd_addr_a,
    input  wire [AW-1:0]                 i_rd_addr_b,
    output logic [spca_pkg::COST_W-1:0]  o_rd_data_a,
    output logic [spca_pkg::COST_W-1:0]  o_rd_data_b,
    input  wire                          i_wr_en,
    input  wire [AW-1:0]                 i_wr_addr,
    input  wire [spca_pkg::COST_W-1:0]   i_wr_data
);
    import spca_pkg::*;

    logic [COST_W-1:0] r_mem [DEPTH];
    logic [COST_W-1:0] r_rd_a;
    logic [COST_W-1:0] r_rd_b;

    // read returns the contents before a write at the same edge
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

`default_nettype wire

// File: design/spca_path_unit.sv
// ----------------------------------------------------------------------------
// spca_path_unit
// per disparity path cost: four way minimum, penalty add, saturating sum
// ----------------------------------------------------------------------------
`default_nettype none

module spca_path_unit (
    input  wire spca_pkg::t_cfg        i_cfg,
    input  wire spca_pkg::t_in_item    i_item,
    input  wire spca_pkg::t_path_state i_state,
    output spca_pkg::t_out_item        o_result
);
    import spca_pkg::*;

    logic [COST_W:0]      cand_low;
    logic [COST_W:0]      cand_up;
    logic [COST_W:0]      cand_jump;
    logic [COST_W:0]      best;
    logic signed [15:0]   raw;
    logic [COST_W-1:0]    cost;
    logic [SUM_W:0]       sum_raw;
    logic                 done;

    always_comb begin
        cand_low  = (COST_W+1)'(i_state.held_lower) + (COST_W+1)'(i_cfg.penalty_small);
        cand_up   = (COST_W+1)'(i_state.old_up) + (COST_W+1)'(i_cfg.penalty_small);
        cand_jump = (COST_W+1)'(i_state.prev_min) + (COST_W+1)'(i_cfg.penalty_large);
        done      = (i_item.disparity == i_cfg.max_disparity);

        best = (COST_W+1)'(i_state.old_here);
        if ((i_item.disparity != '0) && (cand_low < best)) begin
            best = cand_low;
        end
        if ((i_item.disparity < i_cfg.max_disparity) && (cand_up < best)) begin
            best = cand_up;
        end
        if (cand_jump < best) begin
            best = cand_jump;
        end

        raw = $signed(16'(i_item.pixel_cost)) + $signed(16'(best))
            - $signed(16'(i_state.prev_min));

        if (i_item.path_start) begin
            cost = COST_W'(i_item.pixel_cost);
        end else if (raw < 16'sd0) begin
            cost = '0;
        end else if (raw > $signed(16'(COST_MAX))) begin
            cost = COST_MAX;
        end else begin
            cost = raw[COST_W-1:0];
        end

        sum_raw = (SUM_W+1)'(i_item.partial_sum) + (SUM_W+1)'(cost);

        o_result.path_cost  = cost;
        o_result.pixel_done = done;
        if (i_item.path_start) begin
            o_result.new_sum = i_item.partial_sum;
        end else if (sum_raw[SUM_W]) begin
            o_result.new_sum = SUM_MAX;
        end else begin
            o_result.new_sum = sum_raw[SUM_W-1:0];
        end
    end

endmodule

`default_nettype wire

// File: design/sgm_path_cost_aggregation.sv
// ----------------------------------------------------------------------------
// sgm_path_cost_aggregation
// semi-global matching cost aggregation along one path
// ----------------------------------------------------------------------------
// Takes one disparity per cycle while the output is ready, sustaining one
// transaction per clock, and returns one result per transaction through the
// compute stage and output registers. The previous pixel's path costs sit in a
// memory with two registered read ports (disparity d and d+1, read at
// acceptance) and one write port (disparity d, written when the item leaves the
// compute stage). The write of the item in the compute stage is forwarded to a
// read issued at the same edge, so consecutive disparities never stall. The
// store has no reset pass; entries read before they were written are undefined.
// Write the configuration only while no transaction is in flight.
`default_nettype none

module sgm_path_cost_aggregation #(
    parameter int DISPARITY_DEPTH = spca_pkg::DISPARITY_DEPTH_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_ready,
    input  wire spca_pkg::t_in_item          i_in_data,
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output spca_pkg::t_out_item              o_out_data,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire [spca_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire [spca_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import spca_pkg::*;

    localparam int AW = $clog2(DISPARITY_DEPTH);

    t_cfg        cfg;
    t_path_state path_state;
    t_out_item   s1_result;

    logic                r_s1_valid;
    t_in_item            r_s1_item;
    logic                r_here_ok;
    logic                r_up_ok;
    logic                r_fwd_here;
    logic                r_fwd_up;
    logic [COST_W-1:0]   r_fwd_val;
    logic [COST_W-1:0]   r_prev_min;
    logic [COST_W-1:0]   r_cur_min;
    logic [COST_W-1:0]   r_held_lower;
    logic                r_out_valid;
    t_out_item           r_out_item;

    logic [COST_W-1:0]   n_cur_min;
    logic [COST_W-1:0]   run_min;

    logic                accept;
    logic                s1_go;
    logic                s1_wr_ok;
    logic [DISP_W:0]     in_disp_up;
    logic [31:0]         addr_here;
    logic [31:0]         addr_up;
    logic [31:0]         addr_wr;
    logic [COST_W-1:0]   rd_here;
    logic [COST_W-1:0]   rd_up;

    spca_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    assign s1_go      = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_go;
    assign accept     = i_in_valid && o_in_ready;

    assign in_disp_up = (DISP_W+1)'(i_in_data.disparity) + (DISP_W+1)'(1);
    assign addr_here  = 32'(i_in_data.disparity);
    assign addr_up    = 32'(in_disp_up);
    assign addr_wr    = 32'(r_s1_item.disparity);
    assign s1_wr_ok   = addr_wr < 32'(DISPARITY_DEPTH);

    spca_cost_ram #(
        .DEPTH (DISPARITY_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk       (i_clk),
        .i_rd_en     (accept),
        .i_rd_addr_a (addr_here[AW-1:0]),
        .i_rd_addr_b (addr_up[AW-1:0]),
        .o_rd_data_a (rd_here),
        .o_rd_data_b (rd_up),
        .i_wr_en     (s1_go && s1_wr_ok),
        .i_wr_addr   (addr_wr[AW-1:0]),
        .i_wr_data   (s1_result.path_cost)
    );

    // out-of-range disparities read as zero, forwarded data beats the ram
    always_comb begin
        if (!r_here_ok) begin
            path_state.old_here = '0;
        end else if (r_fwd_here) begin
            path_state.old_here = r_fwd_val;
        end else begin
            path_state.old_here = rd_here;
        end
        if (!r_up_ok) begin
            path_state.old_up = '0;
        end else if (r_fwd_up) begin
            path_state.old_up = r_fwd_val;
        end else begin
            path_state.old_up = rd_up;
        end
        path_state.held_lower = r_held_lower;
        path_state.prev_min   = r_prev_min;
    end

    spca_path_unit u_path (
        .i_cfg    (cfg),
        .i_item   (r_s1_item),
        .i_state  (path_state),
        .o_result (s1_result)
    );

    always_comb begin
        run_min = (s1_result.path_cost < r_cur_min) ? s1_result.path_cost : r_cur_min;
        n_cur_min = s1_result.pixel_done ? COST_MAX : run_min;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_prev_min   <= '0;
            r_cur_min    <= COST_MAX;
            r_held_lower <= '0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (s1_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (s1_go) begin
                r_held_lower <= path_state.old_here;
                r_cur_min    <= n_cur_min;
                if (s1_result.pixel_done) begin
                    r_prev_min <= run_min;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_item  <= i_in_data;
            r_here_ok  <= addr_here < 32'(DISPARITY_DEPTH);
            r_up_ok    <= addr_up < 32'(DISPARITY_DEPTH);
            // the compute stage writes at this same edge, the ram read misses it
            r_fwd_here <= s1_go && s1_wr_ok
                          && (r_s1_item.disparity == i_in_data.disparity);
            r_fwd_up   <= s1_go && s1_wr_ok
                          && ((DISP_W+1)'(r_s1_item.disparity) == in_disp_up);
            r_fwd_val  <= s1_result.path_cost;
        end
        if (s1_go) begin
            r_out_item <= s1_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

endmodule

`default_nettype wire
